[rtl/vlbp_pkg.sv]
// Shared constants and types for the variable-length bit packer.
package vlbp_pkg;

  // Fixed widths of the code and result fields
  localparam int CODE_BITS   = 32;
  localparam int LENGTH_BITS = 6;
  localparam int OUT_BITS    = 32;

  // Status of the code queue as seen by its two sides
  typedef struct packed {
    logic not_empty;
    logic not_full;
  } queue_status_t;

endpackage

[rtl/vlbp_front.sv]
// Front end: accepts code beats, clamps the length and masks the code bits.
module vlbp_front #(
  parameter int WORD_BITS = 32,
  parameter int LEN_W     = 6,
  parameter int ITEM_W    = 39
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid,
  output logic                            ready,
  input  logic [vlbp_pkg::CODE_BITS-1:0]   code_value,
  input  logic [vlbp_pkg::LENGTH_BITS-1:0] code_length,
  input  logic                            end_of_stream,
  input  vlbp_pkg::queue_status_t         q_status,
  output logic                            push,
  output logic [ITEM_W-1:0]               push_item
);
  import vlbp_pkg::*;

  localparam logic [6:0] WORD_LEN = 7'(WORD_BITS);

  logic [6:0]           len_ext;
  logic [6:0]           len_clamped;
  logic [CODE_BITS-1:0] code_mask;
  logic [63:0]          code_wide;
  logic                 rst_hold;

  // Hold off input while the registered reset is high
  always_ff @(posedge clk) begin
    if (rst) begin
      rst_hold <= 1'b1;
    end else begin
      rst_hold <= 1'b0;
    end
  end

  assign ready = q_status.not_full && !rst_hold;
  assign push  = valid && ready;

  // Clamp the length to the word size
  always_comb begin
    len_ext     = {1'b0, code_length};
    len_clamped = (len_ext > WORD_LEN) ? WORD_LEN : len_ext;
  end

  // Drop code bits above the length
  always_comb begin
    code_mask = ~({CODE_BITS{1'b1}} << len_clamped);
    code_wide = 64'(code_value & code_mask);
  end

  assign push_item = {end_of_stream, len_clamped[LEN_W-1:0], code_wide[WORD_BITS-1:0]};

endmodule

[rtl/vlbp_queue.sv]
// Two-entry queue that decouples the front end from the packing back end.
module vlbp_queue #(
  parameter int WIDTH = 39
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        push_item,
  input  logic                    pop,
  output logic [WIDTH-1:0]        head_item,
  output vlbp_pkg::queue_status_t status
);
  import vlbp_pkg::*;

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign head_item        = entries[rd_ptr];
  assign status.not_empty = (count != 2'd0);
  assign status.not_full  = (count != 2'd2);

endmodule

[rtl/vlbp_back.sv]
// Back end: appends codes to the accumulator and emits full and final words.
module vlbp_back #(
  parameter int WORD_BITS = 32,
  parameter int LEN_W     = 6,
  parameter int ITEM_W    = 39
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ITEM_W-1:0]            head_item,
  input  vlbp_pkg::queue_status_t      q_status,
  output logic                         pop,
  output logic                         valid,
  input  logic                         ready,
  output logic [vlbp_pkg::OUT_BITS-1:0] packed_word,
  output logic                         final_word
);
  import vlbp_pkg::*;

  localparam logic [LEN_W:0] WORD_LEN = (LEN_W + 1)'(WORD_BITS);

  // Packing state
  logic [WORD_BITS-1:0] acc;
  logic [LEN_W-1:0]     fill;

  // Output register and second-result holding register
  logic                 out_valid;
  logic [OUT_BITS-1:0]  out_word;
  logic                 out_final;
  logic                 pend_valid;
  logic [OUT_BITS-1:0]  pend_word;

  // Unpacked head beat
  logic [WORD_BITS-1:0] code;
  logic [LEN_W-1:0]     len;
  logic                 eos;

  logic [LEN_W:0]       sum;
  logic                 over;
  logic [LEN_W-1:0]     extra;
  logic [LEN_W-1:0]     head;
  logic [WORD_BITS-1:0] full_word;
  logic [WORD_BITS-1:0] acc_mid;
  logic [LEN_W-1:0]     fill_mid;
  logic [LEN_W-1:0]     pad;
  logic [WORD_BITS-1:0] fin_word;
  logic                 has_fin;
  logic [63:0]          full_wide;
  logic [63:0]          fin_wide;
  logic                 slot_free;

  assign {eos, len, code} = head_item;

  // Split the code across the word boundary when it overfills
  always_comb begin
    sum       = {1'b0, fill} + {1'b0, len};
    over      = sum > WORD_LEN;
    extra     = LEN_W'(sum - WORD_LEN);
    head      = LEN_W'(WORD_LEN - {1'b0, fill});
    full_word = (acc << head) | (code >> extra);
    if (over) begin
      acc_mid  = code & ~({WORD_BITS{1'b1}} << extra);
      fill_mid = extra;
    end else begin
      acc_mid  = (acc << len) | code;
      fill_mid = sum[LEN_W-1:0];
    end
  end

  // Left-align the held bits and pad with ones for the flush
  always_comb begin
    pad       = LEN_W'(WORD_LEN - {1'b0, fill_mid});
    fin_word  = (acc_mid << pad) | ~({WORD_BITS{1'b1}} << pad);
    has_fin   = eos && (fill_mid != '0);
    full_wide = 64'(full_word);
    fin_wide  = 64'(fin_word);
  end

  // Take a beat when no result is held back and the output can take its first word, or the beat yields no word
  assign slot_free = !out_valid || ready;
  assign pop       = q_status.not_empty && !pend_valid && (slot_free || (!over && !has_fin));

  // Advance packing state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      fill <= '0;
    end else if (pop) begin
      if (eos) begin
        acc  <= '0;
        fill <= '0;
      end else begin
        acc  <= acc_mid;
        fill <= fill_mid;
      end
    end
  end

  // Load output and holding registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (slot_free && pend_valid) begin
        out_valid  <= 1'b1;
        out_word   <= pend_word;
        out_final  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (pop && (over || has_fin)) begin
        out_valid <= 1'b1;
        out_word  <= over ? full_wide[OUT_BITS-1:0] : fin_wide[OUT_BITS-1:0];
        out_final <= !over;
        if (over && has_fin) begin
          pend_valid <= 1'b1;
          pend_word  <= fin_wide[OUT_BITS-1:0];
        end
      end else if (ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign valid       = out_valid;
  assign packed_word = out_word;
  assign final_word  = out_final;

endmodule

[rtl/variable_length_bit_packer.sv]
// Top level of the variable-length bit packer.
//
// Packs variable-length codes MSB first into words of WORD_BITS bits (8 to 64);
// each result carries the low 32 bits of the word. Code lengths above WORD_BITS
// count as WORD_BITS, and code bits above the length are dropped. A word that is
// exactly full is held until more bits arrive or the stream ends; on end of
// stream the held bits are left-aligned, padded with ones and emitted with
// final_word set. The block takes one code per cycle while its two-entry queue
// has room; the back end retires one queued code per cycle by a shift-and-merge
// unless a held result or a stalled output stops it. A code that yields a full
// and a final word sends the full word first and holds the final one. Results
// sit in an output register, so a new code is accepted while a word waits.
module variable_length_bit_packer #(
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [vlbp_pkg::CODE_BITS-1:0]   code_value,
  input  logic [vlbp_pkg::LENGTH_BITS-1:0] code_length,
  input  logic                            end_of_stream,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vlbp_pkg::OUT_BITS-1:0]    packed_word,
  output logic                            final_word
);
  import vlbp_pkg::*;

  localparam int LEN_W  = $clog2(WORD_BITS + 1);
  localparam int ITEM_W = WORD_BITS + LEN_W + 1;

  queue_status_t     q_status;
  logic              push;
  logic [ITEM_W-1:0] push_item;
  logic              pop;
  logic [ITEM_W-1:0] head_item;

  vlbp_front #(
    .WORD_BITS (WORD_BITS),
    .LEN_W     (LEN_W),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .valid         (in_valid),
    .ready         (in_ready),
    .code_value    (code_value),
    .code_length   (code_length),
    .end_of_stream (end_of_stream),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  vlbp_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  vlbp_back #(
    .WORD_BITS (WORD_BITS),
    .LEN_W     (LEN_W),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_item   (head_item),
    .q_status    (q_status),
    .pop         (pop),
    .valid       (out_valid),
    .ready       (out_ready),
    .packed_word (packed_word),
    .final_word  (final_word)
  );

endmodule
